// ===== rtl/core/ttb_pkg.sv =====
// Shared types and constants of the triangle tangent basis block.
package ttb_pkg;

  localparam int DW = 25;  // width of a position or texture delta
  localparam int NW = 16;  // width of a Q1.14 normal component

  typedef logic [DW-1:0] delta_t;
  typedef logic [NW-1:0] nrm_t;

  // One triangle as handed from the front end to the back end.
  typedef struct packed {
    delta_t [2:0]          e1;
    delta_t [2:0]          e2;
    delta_t                du1;
    delta_t                dv1;
    delta_t                du2;
    delta_t                dv2;
    nrm_t   [2:0][2:0]     nrm;  // [corner][axis]
  } tri_t;

endpackage

// ===== rtl/core/ttb_front.sv =====
// Front end: collects vertices, holds two, forms edge and UV deltas on the third.
module ttb_front import ttb_pkg::*; #(
  parameter int CW = 24,
  parameter int UW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [CW-1:0] pos_x_i,
  input  logic [CW-1:0] pos_y_i,
  input  logic [CW-1:0] pos_z_i,
  input  logic [CW-1:0] tex_u_i,
  input  logic [CW-1:0] tex_v_i,
  input  logic [UW-1:0] normal_x_i,
  input  logic [UW-1:0] normal_y_i,
  input  logic [UW-1:0] normal_z_i,
  input  logic          full_i,
  output logic          push_o,
  output tri_t          push_data_o
);

  localparam int SH  = (CW > DW - 1) ? CW - (DW - 1) : 0;
  localparam int NSL = (UW < NW) ? NW - UW : 0;
  localparam int NSR = (UW > NW) ? UW - NW : 0;

  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  logic [1:0]                 phase_q;
  logic [1:0][2:0][CW-1:0]    pos_q;
  logic [1:0][1:0][CW-1:0]    uv_q;
  logic [1:0][2:0][NW-1:0]    nrm_q;
  logic                       accept;
  logic                       third;
  logic                       slot;
  logic [2:0][CW-1:0]         pos_in;
  logic [2:0][NW-1:0]         nrm_in;

  function automatic delta_t cdelta(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic signed [CW:0] d;
    d = $signed({a[CW-1], a}) - $signed({b[CW-1], b});
    d = d >>> SH;
    return DW'(d);
  endfunction

  function automatic nrm_t cnorm(input logic [UW-1:0] n);
    logic signed [UW+NW-1:0] x;
    x = (UW+NW)'($signed(n));
    x = x <<< NSL;
    x = x >>> NSR;
    return NW'(x);
  endfunction

  assign third      = (phase_q == PH_THIRD);
  assign slot       = (phase_q == PH_SECOND);
  assign in_ready_o = !third || !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && third;

  assign pos_in = {pos_z_i, pos_y_i, pos_x_i};
  assign nrm_in = {cnorm(normal_z_i), cnorm(normal_y_i), cnorm(normal_x_i)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST;
    end else if (accept) begin
      if (third) begin
        phase_q <= PH_FIRST;
      end else if (slot) begin
        phase_q <= PH_THIRD;
      end else begin
        phase_q <= PH_SECOND;
      end
    end
  end

  // Hold the first two vertices of the triangle.
  always_ff @(posedge clk_i) begin
    if (accept && !third) begin
      pos_q[slot] <= pos_in;
      uv_q[slot]  <= {tex_v_i, tex_u_i};
      nrm_q[slot] <= nrm_in;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      push_data_o.e1[i] = cdelta(pos_q[1][i], pos_q[0][i]);
      push_data_o.e2[i] = cdelta(pos_in[i], pos_q[0][i]);
    end
    push_data_o.du1    = cdelta(uv_q[1][0], uv_q[0][0]);
    push_data_o.dv1    = cdelta(uv_q[1][1], uv_q[0][1]);
    push_data_o.du2    = cdelta(tex_u_i, uv_q[0][0]);
    push_data_o.dv2    = cdelta(tex_v_i, uv_q[0][1]);
    push_data_o.nrm[0] = nrm_q[0];
    push_data_o.nrm[1] = nrm_q[1];
    push_data_o.nrm[2] = nrm_in;
  end

endmodule

// ===== rtl/core/ttb_queue.sv =====
// Two-entry triangle queue between the front end and the back end.
module ttb_queue import ttb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  tri_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output tri_t head_o
);

  tri_t       ent_q [2];
  logic       wptr_q;
  logic       rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = ent_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= !wptr_q;
      if (pop_i)  rptr_q <= !rptr_q;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wptr_q] <= push_data_i;
  end

endmodule

// ===== rtl/core/ttb_back.sv =====
// Back end: sequencer with shared multiplier, normalizer, square root and divider.
module ttb_back import ttb_pkg::*; #(
  parameter int UW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  tri_t          head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [UW-1:0] tangent_x_o,
  output logic [UW-1:0] tangent_y_o,
  output logic [UW-1:0] tangent_z_o,
  output logic [1:0]    corner_o,
  output logic          degenerate_o,
  output logic          last_o
);

  localparam int MW   = 34;      // multiplier operand width
  localparam int AW   = 2 * MW;  // product and accumulator width
  localparam int VW   = 64;      // vector width before normalizing
  localparam int RW   = 32;      // normalized vector width
  localparam int DOTW = 50;
  localparam int SPL  = DW;      // split point of the dot product
  localparam int GSH  = 28;
  localparam int FB   = UW - 2;  // fraction bits of the tangent
  localparam int LW   = 32;      // length width

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_DET    = 5'd1;
  localparam logic [4:0] ST_RAW    = 5'd2;
  localparam logic [4:0] ST_RDONE  = 5'd3;
  localparam logic [4:0] ST_DOT    = 5'd4;
  localparam logic [4:0] ST_G      = 5'd5;
  localparam logic [4:0] ST_GDONE  = 5'd6;
  localparam logic [4:0] ST_SQ     = 5'd7;
  localparam logic [4:0] ST_SQRT   = 5'd8;
  localparam logic [4:0] ST_DIV    = 5'd9;
  localparam logic [4:0] ST_B      = 5'd10;
  localparam logic [4:0] ST_BDONE  = 5'd11;
  localparam logic [4:0] ST_C      = 5'd12;
  localparam logic [4:0] ST_CDONE  = 5'd13;
  localparam logic [4:0] ST_BC     = 5'd14;
  localparam logic [4:0] ST_EMIT   = 5'd15;
  localparam logic [4:0] ST_SMAX   = 5'd16;
  localparam logic [4:0] ST_SSHIFT = 5'd17;

  localparam logic [4:0] SQRT_LAST = 5'd31;
  localparam logic [4:0] DIV_LAST  = 5'(FB + 1);
  localparam logic [1:0] IDX_LAST  = 2'd2;

  // control
  logic [4:0] state_q, state_d, ret_q, ret_d;
  logic [2:0] st_q, st_d;
  logic [1:0] idx_q, idx_d, corner_q, corner_d;
  logic [4:0] cnt_q, cnt_d;
  logic       pval_q, out_valid_q;
  logic       emit, issue, mac_end, is_mac;
  logic [2:0] n_ops;

  // datapath
  tri_t                    tri_q;
  logic signed [AW-1:0]    prod_q, acc_q, addend, acc_init;
  logic                    pneg_q, psh_q, oneg, osh;
  logic signed [MW-1:0]    opa, opb;
  logic [1:0]              opi, j1, j2;
  logic                    det_neg_q, det_zero_q, len_zero_q, flip_q;
  logic signed [VW-1:0]    v_q [3];
  logic [VW-1:0]           m_q, vmag;
  logic                    sh_right, sh_left;
  logic signed [RW-1:0]    r_q [3];
  logic signed [RW-1:0]    g_q [3];
  logic signed [RW-1:0]    b_q [3];
  logic signed [UW-1:0]    t_q [3];
  logic signed [DOTW-1:0]  dot_q;
  logic [VW-1:0]           sx_q, sres_q, sbit_q, strial, sx_nxt, sres_nxt;
  logic [LW:0]             rem_q, cur, rem_nxt, gmag;
  logic                    ge;
  logic [UW-2:0]           quo_q;
  logic [UW:0]             qsum;
  logic [UW-1:0]           qv;
  logic signed [UW-1:0]    tout [3];
  logic                    degen;

  function automatic logic signed [MW-1:0] xd(input delta_t x);
    return MW'($signed(x));
  endfunction

  function automatic logic signed [MW-1:0] xn(input nrm_t x);
    return MW'($signed(x));
  endfunction

  function automatic logic [1:0] nxt(input logic [1:0] i);
    return (i == IDX_LAST) ? 2'd0 : i + 2'd1;
  endfunction

  assign opi = (st_q[1:0] == 2'd3) ? 2'd0 : st_q[1:0];
  assign j1  = nxt(idx_q);
  assign j2  = nxt(j1);

  // Operand selection for the shared multiplier.
  always_comb begin
    n_ops    = 3'd0;
    opa      = '0;
    opb      = '0;
    oneg     = 1'b0;
    osh      = 1'b0;
    acc_init = '0;
    case (state_q)
      ST_DET: begin
        n_ops = 3'd2;
        opa   = st_q[0] ? xd(tri_q.dv1) : xd(tri_q.du1);
        opb   = st_q[0] ? xd(tri_q.du2) : xd(tri_q.dv2);
        oneg  = st_q[0];
      end
      ST_RAW: begin
        n_ops = 3'd2;
        opa   = st_q[0] ? xd(tri_q.dv1) : xd(tri_q.dv2);
        opb   = st_q[0] ? xd(tri_q.e2[idx_q]) : xd(tri_q.e1[idx_q]);
        oneg  = st_q[0];
      end
      ST_DOT: begin
        n_ops = 3'd3;
        opa   = xn(tri_q.nrm[corner_q][opi]);
        opb   = MW'(r_q[opi]);
      end
      ST_G: begin
        n_ops    = 3'd2;
        opa      = xn(tri_q.nrm[corner_q][idx_q]);
        opb      = st_q[0] ? MW'({1'b0, dot_q[SPL-1:0]}) : MW'(dot_q >>> SPL);
        oneg     = 1'b1;
        osh      = !st_q[0];
        acc_init = AW'(r_q[idx_q]) <<< GSH;
      end
      ST_SQ: begin
        n_ops = 3'd3;
        opa   = MW'(g_q[opi]);
        opb   = MW'(g_q[opi]);
      end
      ST_B: begin
        n_ops = 3'd2;
        opa   = st_q[0] ? xn(tri_q.nrm[corner_q][j2]) : xn(tri_q.nrm[corner_q][j1]);
        opb   = st_q[0] ? MW'(r_q[j1]) : MW'(r_q[j2]);
        oneg  = st_q[0];
      end
      ST_C: begin
        n_ops = 3'd2;
        opa   = st_q[0] ? xn(tri_q.nrm[corner_q][j2]) : xn(tri_q.nrm[corner_q][j1]);
        opb   = st_q[0] ? MW'(t_q[j1]) : MW'(t_q[j2]);
        oneg  = st_q[0];
      end
      ST_BC: begin
        n_ops = 3'd3;
        opa   = MW'(b_q[opi]);
        opb   = MW'(v_q[opi]);
      end
      default: ;
    endcase
  end

  assign is_mac  = (n_ops != 3'd0);
  assign issue   = is_mac && (st_q < n_ops);
  assign mac_end = is_mac && (st_q == n_ops + 3'd1);

  always_comb begin
    addend = prod_q;
    if (psh_q)  addend = addend <<< SPL;
    if (pneg_q) addend = -addend;
  end

  // normalizer
  assign vmag     = v_q[idx_q][VW-1] ? VW'(-v_q[idx_q]) : VW'(v_q[idx_q]);
  assign sh_right = (m_q >= (VW'(1) << 30));
  assign sh_left  = (m_q != '0) && (m_q < (VW'(1) << 29));

  // square root, one result bit per cycle
  assign strial   = sres_q + sbit_q;
  assign sx_nxt   = (sx_q >= strial) ? sx_q - strial : sx_q;
  assign sres_nxt = (sx_q >= strial) ? (sres_q >> 1) + sbit_q : sres_q >> 1;

  // restoring divider, one quotient bit per cycle
  assign gmag    = g_q[idx_q][RW-1] ? (LW+1)'(-g_q[idx_q]) : (LW+1)'(g_q[idx_q]);
  assign cur     = (cnt_q == '0) ? gmag : {rem_q[LW-1:0], 1'b0};
  assign ge      = (cur >= {1'b0, sres_q[LW-1:0]});
  assign rem_nxt = ge ? cur - {1'b0, sres_q[LW-1:0]} : cur;
  assign qsum    = (UW+1)'({quo_q, ge}) + (UW+1)'(1);
  assign qv      = qsum[UW:1];

  always_comb begin
    state_d  = state_q;
    ret_d    = ret_q;
    st_d     = st_q;
    idx_d    = idx_q;
    cnt_d    = cnt_q;
    corner_d = corner_q;
    pop_o    = 1'b0;
    emit     = 1'b0;
    if (is_mac) st_d = mac_end ? 3'd0 : st_q + 3'd1;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = ST_DET;
        end
      end
      ST_DET: begin
        if (mac_end) begin
          idx_d    = 2'd0;
          corner_d = 2'd0;
          state_d  = (acc_q == '0) ? ST_EMIT : ST_RAW;
        end
      end
      ST_RAW, ST_G, ST_B, ST_C: begin
        if (mac_end) begin
          if (idx_q == IDX_LAST) begin
            idx_d   = 2'd0;
            state_d = ST_SMAX;
            case (state_q)
              ST_RAW:  ret_d = ST_RDONE;
              ST_G:    ret_d = ST_GDONE;
              ST_B:    ret_d = ST_BDONE;
              default: ret_d = ST_CDONE;
            endcase
          end else begin
            idx_d = idx_q + 2'd1;
          end
        end
      end
      ST_RDONE: state_d = ST_DOT;
      ST_DOT: begin
        if (mac_end) begin
          idx_d   = 2'd0;
          state_d = ST_G;
        end
      end
      ST_GDONE: state_d = ST_SQ;
      ST_SQ: begin
        if (mac_end) begin
          cnt_d   = '0;
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == SQRT_LAST) begin
          cnt_d   = '0;
          idx_d   = 2'd0;
          state_d = (sres_nxt == '0) ? ST_EMIT : ST_DIV;
        end
      end
      ST_DIV: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == DIV_LAST) begin
          cnt_d = '0;
          if (idx_q == IDX_LAST) begin
            idx_d   = 2'd0;
            state_d = ST_B;
          end else begin
            idx_d = idx_q + 2'd1;
          end
        end
      end
      ST_BDONE: begin
        idx_d   = 2'd0;
        state_d = ST_C;
      end
      ST_CDONE: state_d = ST_BC;
      ST_BC: begin
        if (mac_end) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          emit = 1'b1;
          if (corner_q == IDX_LAST) begin
            state_d = ST_IDLE;
          end else begin
            corner_d = corner_q + 2'd1;
            state_d  = det_zero_q ? ST_EMIT : ST_DOT;
          end
        end
      end
      ST_SMAX: begin
        idx_d = idx_q + 2'd1;
        if (idx_q == IDX_LAST) begin
          idx_d   = 2'd0;
          state_d = ST_SSHIFT;
        end
      end
      ST_SSHIFT: begin
        if (!sh_right && !sh_left) state_d = ret_q;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ret_q       <= ST_IDLE;
      st_q        <= 3'd0;
      idx_q       <= 2'd0;
      cnt_q       <= '0;
      corner_q    <= 2'd0;
      pval_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ret_q    <= ret_d;
      st_q     <= st_d;
      idx_q    <= idx_d;
      cnt_q    <= cnt_d;
      corner_q <= corner_d;
      pval_q   <= issue;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign degen = det_zero_q || len_zero_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (degen) begin
        tout[i] = '0;
      end else begin
        tout[i] = flip_q ? -t_q[i] : t_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) tri_q <= head_i;
    if (issue) begin
      prod_q <= opa * opb;
      pneg_q <= oneg;
      psh_q  <= osh;
    end
    if (is_mac && st_q == 3'd0) begin
      acc_q <= acc_init;
    end else if (pval_q) begin
      acc_q <= acc_q + addend;
    end
    case (state_q)
      ST_DET: begin
        if (mac_end) begin
          det_neg_q  <= acc_q[AW-1];
          det_zero_q <= (acc_q == '0);
        end
      end
      ST_RAW: begin
        if (mac_end) v_q[idx_q] <= VW'(det_neg_q ? -acc_q : acc_q);
      end
      ST_G, ST_B, ST_C: begin
        if (mac_end) v_q[idx_q] <= VW'(acc_q);
      end
      ST_RDONE: begin
        for (int i = 0; i < 3; i++) r_q[i] <= RW'(v_q[i]);
      end
      ST_DOT: begin
        if (mac_end) dot_q <= DOTW'(acc_q);
      end
      ST_GDONE: begin
        for (int i = 0; i < 3; i++) g_q[i] <= RW'(v_q[i]);
      end
      ST_SQ: begin
        if (mac_end) begin
          sx_q   <= VW'(acc_q);
          sres_q <= '0;
          sbit_q <= VW'(1) << (VW - 2);
        end
      end
      ST_SQRT: begin
        sx_q   <= sx_nxt;
        sres_q <= sres_nxt;
        sbit_q <= sbit_q >> 2;
        if (cnt_q == SQRT_LAST) len_zero_q <= (sres_nxt == '0);
      end
      ST_DIV: begin
        rem_q <= rem_nxt;
        quo_q <= {quo_q[UW-3:0], ge};
        if (cnt_q == DIV_LAST) begin
          t_q[idx_q] <= g_q[idx_q][RW-1] ? -$signed(qv) : $signed(qv);
        end
      end
      ST_BDONE: begin
        for (int i = 0; i < 3; i++) b_q[i] <= RW'(v_q[i]);
      end
      ST_BC: begin
        if (mac_end) flip_q <= acc_q[AW-1];
      end
      ST_EMIT: begin
        if (emit) begin
          tangent_x_o  <= tout[0];
          tangent_y_o  <= tout[1];
          tangent_z_o  <= tout[2];
          corner_o     <= corner_q;
          degenerate_o <= degen;
          last_o       <= (corner_q == IDX_LAST);
        end
      end
      ST_SMAX: begin
        if (idx_q == 2'd0 || vmag > m_q) m_q <= vmag;
      end
      ST_SSHIFT: begin
        if (sh_right) begin
          for (int i = 0; i < 3; i++) v_q[i] <= v_q[i] >>> 1;
          m_q <= m_q >> 1;
        end else if (sh_left) begin
          for (int i = 0; i < 3; i++) v_q[i] <= v_q[i] <<< 1;
          m_q <= m_q << 1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/triangle_tangent_basis.sv =====
// Per-triangle tangent basis: vertex collector, triangle queue and compute back end.
// Vertices are taken one per cycle, but a third vertex waits while the queue is full;
// every third vertex queues one triangle (two deep). Back end work per triangle is set
// by the one-bit-per-cycle normalizing shifter, the 32-step square root and a
// UNIT_WIDTH-step divider per axis, all skipped on a zero UV determinant; each triangle
// gives three words. Reset clears phase, queue and sequencer only.
module triangle_tangent_basis import ttb_pkg::*; #(
  parameter int COORD_WIDTH = 24,
  parameter int UNIT_WIDTH  = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [COORD_WIDTH-1:0] pos_x_i,
  input  logic [COORD_WIDTH-1:0] pos_y_i,
  input  logic [COORD_WIDTH-1:0] pos_z_i,
  input  logic [COORD_WIDTH-1:0] tex_u_i,
  input  logic [COORD_WIDTH-1:0] tex_v_i,
  input  logic [UNIT_WIDTH-1:0]  normal_x_i,
  input  logic [UNIT_WIDTH-1:0]  normal_y_i,
  input  logic [UNIT_WIDTH-1:0]  normal_z_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [UNIT_WIDTH-1:0]  tangent_x_o,
  output logic [UNIT_WIDTH-1:0]  tangent_y_o,
  output logic [UNIT_WIDTH-1:0]  tangent_z_o,
  output logic [1:0]             corner_o,
  output logic                   degenerate_o,
  output logic                   last_o
);

  logic push, full, pop, empty;
  tri_t push_data, head;

  ttb_front #(
    .CW(COORD_WIDTH),
    .UW(UNIT_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .pos_z_i     (pos_z_i),
    .tex_u_i     (tex_u_i),
    .tex_v_i     (tex_v_i),
    .normal_x_i  (normal_x_i),
    .normal_y_i  (normal_y_i),
    .normal_z_i  (normal_z_i),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  ttb_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  ttb_back #(
    .UW(UNIT_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .tangent_x_o  (tangent_x_o),
    .tangent_y_o  (tangent_y_o),
    .tangent_z_o  (tangent_z_o),
    .corner_o     (corner_o),
    .degenerate_o (degenerate_o),
    .last_o       (last_o)
  );

endmodule

// ===== tb/tb_triangle_tangent_basis.sv =====
// Testbench for triangle_tangent_basis: directed and random triangles against a predictor.
module tb_triangle_tangent_basis;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 24;
  localparam int UW = 16;
  localparam longint CYCLE_LIMIT = 2000000;
  localparam int MAX_SHOWN = 10;

  typedef longint v3_t [3];

  typedef struct {
    logic signed [CW-1:0] px, py, pz, tu, tv;
    logic signed [UW-1:0] nx, ny, nz;
  } vertex_t;

  typedef struct {
    logic [UW-1:0] tx, ty, tz;
    logic [1:0]    corner;
    logic          degen;
    logic          last;
  } tangent_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [CW-1:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0, tex_u_i = '0, tex_v_i = '0;
  logic [UW-1:0] normal_x_i = '0, normal_y_i = '0, normal_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [UW-1:0] tangent_x_o, tangent_y_o, tangent_z_o;
  logic [1:0] corner_o;
  logic degenerate_o, last_o;

  tangent_word_t tangent_q[$];
  vertex_t held_vtx[2];
  int vtx_phase = 0;
  int mismatches = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  longint cycles = 0;

  triangle_tangent_basis #(.COORD_WIDTH(CW), .UNIT_WIDTH(UW)) i_dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[triangle_tangent_basis] ERROR");
      $finish;
    end
  end

  // ---------------- predictor ----------------
  function automatic longint unsigned mag(longint x);
    return x < 0 ? 64'd0 - longint'(x) : x;
  endfunction

  function automatic v3_t scale3(v3_t v);
    longint unsigned m;
    int k;
    m = mag(v[0]);
    k = 0;
    if (mag(v[1]) > m) m = mag(v[1]);
    if (mag(v[2]) > m) m = mag(v[2]);
    if (m == 0) return v;
    if (m >= (64'd1 << 30)) begin
      while ((m >> k) >= (64'd1 << 30)) k++;
      for (int i = 0; i < 3; i++) v[i] = v[i] >>> k;
    end else begin
      while ((m << k) < (64'd1 << 29)) k++;
      for (int i = 0; i < 3; i++) v[i] = v[i] << k;
    end
    return v;
  endfunction

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else res >>= 1;
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic v3_t cross3(v3_t a, v3_t b);
    v3_t o;
    o[0] = a[1] * b[2] - a[2] * b[1];
    o[1] = a[2] * b[0] - a[0] * b[2];
    o[2] = a[0] * b[1] - a[1] * b[0];
    return o;
  endfunction

  // Orthogonalize r against n, normalize, fix handedness.
  function automatic tangent_word_t corner_tangent(v3_t r, v3_t n, int corner);
    tangent_word_t w;
    v3_t g, t, b, c;
    longint dot;
    longint unsigned len, q, one;
    one = 64'd1 << (UW - 2);
    w.corner = corner[1:0];
    w.last = (corner == 2);
    dot = n[0] * r[0] + n[1] * r[1] + n[2] * r[2];
    for (int i = 0; i < 3; i++) g[i] = (r[i] << 28) - n[i] * dot;
    g = scale3(g);
    len = isqrt(g[0] * g[0] + g[1] * g[1] + g[2] * g[2]);
    if (len == 0) begin
      w.tx = '0; w.ty = '0; w.tz = '0; w.degen = 1'b1;
      return w;
    end
    for (int i = 0; i < 3; i++) begin
      q = (2 * mag(g[i]) * one + len) / (2 * len);
      t[i] = g[i] < 0 ? -longint'(q) : longint'(q);
    end
    b = scale3(cross3(n, r));
    c = scale3(cross3(n, t));
    if (b[0] * c[0] + b[1] * c[1] + b[2] * c[2] < 0)
      for (int i = 0; i < 3; i++) t[i] = -t[i];
    w.tx = t[0][UW-1:0]; w.ty = t[1][UW-1:0]; w.tz = t[2][UW-1:0];
    w.degen = 1'b0;
    return w;
  endfunction

  function automatic void predict_triangle(vertex_t v0, vertex_t v1, vertex_t v2);
    v3_t e1, e2, r, n;
    vertex_t vs[3];
    longint du1, dv1, du2, dv2, det;
    tangent_word_t w;
    vs[0] = v0; vs[1] = v1; vs[2] = v2;
    e1[0] = longint'(v1.px) - v0.px; e1[1] = longint'(v1.py) - v0.py;
    e1[2] = longint'(v1.pz) - v0.pz;
    e2[0] = longint'(v2.px) - v0.px; e2[1] = longint'(v2.py) - v0.py;
    e2[2] = longint'(v2.pz) - v0.pz;
    du1 = longint'(v1.tu) - v0.tu; dv1 = longint'(v1.tv) - v0.tv;
    du2 = longint'(v2.tu) - v0.tu; dv2 = longint'(v2.tv) - v0.tv;
    det = du1 * dv2 - dv1 * du2;
    for (int i = 0; i < 3; i++) begin
      r[i] = dv2 * e1[i] - dv1 * e2[i];
      if (det < 0) r[i] = -r[i];
    end
    r = scale3(r);
    for (int k = 0; k < 3; k++) begin
      n[0] = vs[k].nx; n[1] = vs[k].ny; n[2] = vs[k].nz;
      if (det != 0) w = corner_tangent(r, n, k);
      else begin
        w.tx = '0; w.ty = '0; w.tz = '0; w.degen = 1'b1;
        w.corner = k[1:0]; w.last = (k == 2);
      end
      tangent_q.insert(tangent_q.size(), w);
    end
  endfunction

  function automatic void take_vertex(vertex_t v);
    if (vtx_phase < 2) begin
      held_vtx[vtx_phase] = v;
      vtx_phase++;
    end else begin
      predict_triangle(held_vtx[0], held_vtx[1], v);
      vtx_phase = 0;
    end
  endfunction

  // ---------------- sender ----------------
  task automatic send_vertex(vertex_t v);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    pos_x_i = v.px; pos_y_i = v.py; pos_z_i = v.pz;
    tex_u_i = v.tu; tex_v_i = v.tv;
    normal_x_i = v.nx; normal_y_i = v.ny; normal_z_i = v.nz;
    do @(posedge clk_i); while (!in_ready_o);
    take_vertex(v);
    @(negedge clk_i);
  endtask

  function automatic vertex_t mk_vertex(int px, int py, int pz, int tu, int tv,
                                        int nx, int ny, int nz);
    vertex_t v;
    v.px = CW'(px); v.py = CW'(py); v.pz = CW'(pz); v.tu = CW'(tu); v.tv = CW'(tv);
    v.nx = UW'(nx); v.ny = UW'(ny); v.nz = UW'(nz);
    return v;
  endfunction

  function automatic logic signed [CW-1:0] rand_coord();
    if ($urandom_range(3) == 0) return CW'($urandom);
    return CW'($signed($urandom_range(524287)) - 262144);
  endfunction

  function automatic vertex_t rand_vertex();
    vertex_t v;
    v.px = rand_coord(); v.py = rand_coord(); v.pz = rand_coord();
    v.tu = rand_coord(); v.tv = rand_coord();
    if ($urandom_range(2) == 0) begin
      v.nx = UW'($urandom); v.ny = UW'($urandom); v.nz = UW'($urandom);
    end else begin
      // near-unit normal: dominant axis plus small tilt
      v.nx = UW'($signed($urandom_range(4000)) - 2000);
      v.ny = UW'($signed($urandom_range(4000)) - 2000);
      v.nz = $urandom_range(1) ? 16'sd15000 : -16'sd15000;
    end
    return v;
  endfunction

  task automatic send_random_triangles(int count);
    for (int i = 0; i < 3 * count; i++) send_vertex(rand_vertex());
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    wait (tangent_q.size() == 0);
    repeat (1000) @(negedge clk_i);
  endtask

  // ---------------- receiver and checker ----------------
  always @(negedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 4000;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i = 1'b0;
    end else out_ready_i = ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    tangent_word_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (tangent_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected tangent word x=%h y=%h z=%h corner=%0d",
                   tangent_x_o, tangent_y_o, tangent_z_o, corner_o);
      end else begin
        w = tangent_q.pop_front();
        if (tangent_x_o !== w.tx || tangent_y_o !== w.ty || tangent_z_o !== w.tz ||
            corner_o !== w.corner || degenerate_o !== w.degen || last_o !== w.last) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("mismatch exp %h %h %h c=%0d d=%b l=%b got %h %h %h c=%0d d=%b l=%b",
                     w.tx, w.ty, w.tz, w.corner, w.degen, w.last, tangent_x_o,
                     tangent_y_o, tangent_z_o, corner_o, degenerate_o, last_o);
        end
      end
    end
  end

  // ---------------- tests ----------------
  task automatic test_basic();
    send_vertex(mk_vertex(0, 0, 0, 0, 0, 0, 0, 16384));
    send_vertex(mk_vertex(65536, 0, 0, 65536, 0, 0, 0, 16384));
    send_vertex(mk_vertex(0, 65536, 0, 0, 65536, 0, 0, 16384));
    // mirrored UVs: negative determinant
    send_vertex(mk_vertex(0, 0, 0, 0, 0, 0, 0, -16384));
    send_vertex(mk_vertex(65536, 0, 0, -65536, 0, 0, 0, -16384));
    send_vertex(mk_vertex(0, 65536, 0, 0, 65536, 0, 11585, 11585));
  endtask

  task automatic test_degenerate();
    // same UV on all corners: zero determinant
    send_vertex(mk_vertex(1, 2, 3, 500, 500, 0, 16384, 0));
    send_vertex(mk_vertex(9000, 2, 3, 500, 500, 0, 16384, 0));
    send_vertex(mk_vertex(1, 7000, 3, 500, 500, 0, 16384, 0));
    // tangent parallel to a unit normal: zero length; zero normal on last corner
    send_vertex(mk_vertex(0, 0, 0, 0, 0, 16384, 0, 0));
    send_vertex(mk_vertex(65536, 0, 0, 65536, 0, 0, 16384, 0));
    send_vertex(mk_vertex(0, 65536, 0, 0, 65536, 0, 0, 0));
  endtask

  task automatic test_extremes();
    send_vertex(mk_vertex(-8388608, -8388608, -8388608, -8388608, -8388608,
                          -32768, -32768, -32768));
    send_vertex(mk_vertex(8388607, 8388607, -8388608, 8388607, -8388608,
                          32767, 32767, 32767));
    send_vertex(mk_vertex(-8388608, 8388607, 8388607, -8388608, 8388607,
                          -32768, 32767, 0));
    send_vertex(mk_vertex(8388607, -8388608, 0, 8388607, 8388607, 32767, 0, -32768));
    send_vertex(mk_vertex(-1, 1, -1, -8388608, -1, -1, 1, -1));
    send_vertex(mk_vertex(0, -1, 8388607, 0, -8388608, 0, -32768, 32767));
  endtask

  task automatic test_random_traffic();
    tx_idle_pct = 24; rx_idle_pct = 75;
    send_random_triangles(19);
    tx_idle_pct = 75; rx_idle_pct = 24;
    send_random_triangles(19);
    tx_idle_pct = 0; rx_idle_pct = 0;
    send_random_triangles(19);
  endtask

  task automatic test_backpressure();
    hold_req++;
    send_random_triangles(4);
    // sender pauses until every tangent is out
    drain();
    send_random_triangles(2);
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_basic();
    test_degenerate();
    test_extremes();
    test_random_traffic();
    test_backpressure();
    drain();
    if (mismatches == 0) $display("[triangle_tangent_basis] OK");
    else $display("[triangle_tangent_basis] ERROR");
    $finish;
  end
endmodule
